[hdl/mtf_pkg.sv]
// shared constants and types for the move-to-front codec
// used by the channel interfaces, the list cell and the top level
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int SYM_W         = 8;
    localparam int IDX_W         = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam logic [SYM_W-1:0] SYM_MAX = SYM_W'(ALPHABET_SIZE - 1);

    // traveling token, handed from one cell to the next
    typedef struct packed {
        logic             active;
        logic             found;
        logic [SYM_W-1:0] carry;
        logic [SYM_W-1:0] res;
    } token_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic             decode;
        logic             clear;
        logic [SYM_W-1:0] key;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

endpackage

[hdl/mtf_if.sv]
// valid/ready channel interfaces for the move-to-front codec
// depends on mtf_pkg for the symbol width
`timescale 1ns / 1ps

interface mtf_in_if;
    logic                      valid;
    logic                      ready;
    logic [mtf_pkg::SYM_W-1:0] symbol;
    logic                      block_last;

    modport source (output valid, output symbol, output block_last, input ready);
    modport sink   (input valid, input symbol, input block_last, output ready);
endinterface

interface mtf_out_if;
    logic                      valid;
    logic                      ready;
    logic [mtf_pkg::SYM_W-1:0] coded_value;
    logic                      result_last;

    modport source (output valid, output coded_value, output result_last, input ready);
    modport sink   (input valid, input coded_value, input result_last, output ready);
endinterface

[hdl/mtf_cell.sv]
// one entry of the recency list with its token stage
// depends on mtf_pkg for token_t and cell_ctrl_t
`timescale 1ns / 1ps

module mtf_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mtf_pkg::IDX_W-1:0] idx,
    input  mtf_pkg::cell_ctrl_t       ctrl,
    input  logic                      front_wr,
    input  logic [mtf_pkg::SYM_W-1:0] front_val,
    input  mtf_pkg::token_t           tok_in,
    output mtf_pkg::token_t           tok_out
);

    logic [mtf_pkg::SYM_W-1:0] value_reg;
    logic [mtf_pkg::SYM_W-1:0] value_next;
    mtf_pkg::token_t           tok_reg;
    mtf_pkg::token_t           tok_next;
    logic [mtf_pkg::SYM_W-1:0] own_idx;
    logic                      hit;
    logic                      work;

    assign own_idx = mtf_pkg::SYM_W'(idx);
    assign hit     = ctrl.decode ? (own_idx == ctrl.key) : (value_reg == ctrl.key);
    assign work    = tok_in.active && !tok_in.found;

    always_comb
    begin
        value_next = value_reg;
        tok_next   = tok_in;
        if (ctrl.clear)
        begin
            value_next = own_idx;
        end
        else if (front_wr)
        begin
            value_next = front_val;
        end
        else if (work)
        begin
            // shift back: take the neighbor's entry, pass ours on
            value_next     = tok_in.carry;
            tok_next.carry = value_reg;
            if (hit)
            begin
                tok_next.found = 1'b1;
                tok_next.res   = ctrl.decode ? value_reg : own_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= mtf_pkg::SYM_W'(idx);
            tok_reg   <= '0;
        end
        else
        begin
            value_reg <= value_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hdl/move_to_front_codec.sv]
// move-to-front coder/decoder top level: sequencer, output register, cell chain
// depends on mtf_pkg, mtf_if and mtf_cell
`timescale 1ns / 1ps

// Move-to-front codec over a list of ALPHABET_SIZE (256) symbols, held one
// entry per cell in a chain of cells. decode_mode (cfg_wr_data, written with
// cfg_wr_en) picks the direction: 0 maps symbols to list positions, 1 maps
// positions back to symbols; write it only while the block is idle. Each
// accepted transaction launches a token at the head of the chain that walks
// one cell per clock, shifting entries back until it meets the matching entry
// (encode: same symbol, decode: same position), then carries the result to
// the tail; the head entry is then loaded with the symbol. The result is
// registered in the output register once the token has walked the whole
// chain, and the input is then ready for the next transaction. One item is
// in flight at a time. A finished result waits in the output register while
// the next transaction is accepted; if the output register is still full when
// the next result is formed, that result is held and the input stays blocked
// until the output register drains. After an item with block_last set the
// list returns to identity order in the same cycle its result is formed.
// Symbols beyond the alphabet saturate to its last entry.

module move_to_front_codec
(
    input  logic                      clk,
    input  logic                      rst_n,
    mtf_in_if.sink                    din,
    mtf_out_if.source                 dout,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data
);

    // configuration
    logic decode_mode_reg;

    // sequencer state
    mtf_pkg::state_t           state_reg;
    mtf_pkg::state_t           state_next;
    logic                      start_reg;
    logic                      start_next;
    logic [mtf_pkg::SYM_W-1:0] key_reg;
    logic [mtf_pkg::SYM_W-1:0] key_next;
    logic                      last_reg;
    logic                      last_next;

    // result waiting for a busy output register
    logic [mtf_pkg::SYM_W-1:0] pend_value_reg;
    logic [mtf_pkg::SYM_W-1:0] pend_value_next;
    logic                      pend_last_reg;
    logic                      pend_last_next;

    // output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [mtf_pkg::SYM_W-1:0] out_value_reg;
    logic [mtf_pkg::SYM_W-1:0] out_value_next;
    logic                      out_last_reg;
    logic                      out_last_next;

    // chain wiring: slot 0 is the injected token, slot g+1 leaves cell g
    mtf_pkg::token_t           tok_chain [mtf_pkg::ALPHABET_SIZE+1];
    mtf_pkg::token_t           tok_exit;
    mtf_pkg::cell_ctrl_t       ctrl;
    logic                      front_wr;
    logic [mtf_pkg::SYM_W-1:0] front_val;

    logic                      in_take;
    logic                      out_free;
    logic                      exit_now;
    logic [mtf_pkg::SYM_W-1:0] res_value;
    logic [mtf_pkg::SYM_W-1:0] sym_sat;

    assign in_take  = din.valid && din.ready;
    assign out_free = !out_valid_reg || dout.ready;
    assign tok_exit = tok_chain[mtf_pkg::ALPHABET_SIZE];
    assign exit_now = (state_reg == mtf_pkg::ST_RUN) && tok_exit.active;
    assign res_value = tok_exit.res;

    // clamp out-of-alphabet input so the list stays a permutation
    assign sym_sat = (din.symbol > mtf_pkg::SYM_MAX) ? mtf_pkg::SYM_MAX : din.symbol;

    assign din.ready = (state_reg == mtf_pkg::ST_IDLE);

    // token launched the cycle after acceptance, once key_reg holds the symbol
    assign tok_chain[0] = '{active: start_reg, found: 1'b0,
                            carry: '0, res: '0};

    // broadcast to the cells; the list is rebuilt when the token leaves
    assign ctrl.decode = decode_mode_reg;
    assign ctrl.key    = key_reg;
    assign ctrl.clear  = exit_now && last_reg;
    assign front_wr    = exit_now && !last_reg;
    // the symbol that moves to the head: the input in encode, the lookup in decode
    assign front_val   = decode_mode_reg ? res_value : key_reg;

    always_comb
    begin
        state_next      = state_reg;
        start_next      = 1'b0;
        key_next        = key_reg;
        last_next       = last_reg;
        pend_value_next = pend_value_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !dout.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            mtf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    key_next   = sym_sat;
                    last_next  = din.block_last;
                    start_next = 1'b1;
                    state_next = mtf_pkg::ST_RUN;
                end
            end
            mtf_pkg::ST_RUN:
            begin
                if (tok_exit.active)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = res_value;
                        out_last_next  = last_reg;
                        state_next     = mtf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pend_value_next = res_value;
                        pend_last_next  = last_reg;
                        state_next      = mtf_pkg::ST_HOLD;
                    end
                end
            end
            mtf_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pend_value_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = mtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
            state_reg       <= mtf_pkg::ST_IDLE;
            start_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decode_mode_reg <= cfg_wr_data;
            end
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        last_reg       <= last_next;
        pend_value_reg <= pend_value_next;
        pend_last_reg  <= pend_last_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign dout.valid       = out_valid_reg;
    assign dout.coded_value = out_value_reg;
    assign dout.result_last = out_last_reg;

    // the list itself: one cell per entry, token handed down each clock
    for (genvar g = 0; g < mtf_pkg::ALPHABET_SIZE; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            mtf_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (mtf_pkg::IDX_W'(g)),
                .ctrl      (ctrl),
                .front_wr  (front_wr),
                .front_val (front_val),
                .tok_in    (tok_chain[g]),
                .tok_out   (tok_chain[g+1])
            );
        end
        else
        begin : g_body
            mtf_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (mtf_pkg::IDX_W'(g)),
                .ctrl      (ctrl),
                .front_wr  (1'b0),
                .front_val (front_val),
                .tok_in    (tok_chain[g]),
                .tok_out   (tok_chain[g+1])
            );
        end
    end

endmodule

[tb/mtf_checker.sv]
// scoreboard for the move-to-front codec: watches both channels and the mode port,
// predicts each result from its own recency list and compares field by field
// depends on mtf_pkg and the channel interfaces in mtf_if
`timescale 1ns / 1ps

module mtf_checker
    import mtf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mtf_in_if    din,
    mtf_out_if   dout,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    output int   pending,
    output int   fail_count
);

    typedef struct packed {
        logic [SYM_W-1:0] coded_value;
        logic             result_last;
    } mtf_result_t;

    logic [SYM_W-1:0] recency [ALPHABET_SIZE];
    logic             decoding;
    mtf_result_t      expected_codes [$];
    int               mismatches;

    task automatic restore_identity();
        for (int i = 0; i < ALPHABET_SIZE; i++)
            recency[i] = SYM_W'(i);
    endtask

    // look up (or index) the byte, emit the result, then move the symbol to the head
    task automatic code_byte(input logic [SYM_W-1:0] sym, input logic last,
                             output mtf_result_t res);
        logic [SYM_W-1:0] key;
        logic [SYM_W-1:0] moved;
        int               pos;
        key = (sym > SYM_MAX) ? SYM_MAX : sym;
        pos = 0;
        if (decoding)
            pos = key;
        else
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                if (recency[i] == key)
                begin
                    pos = i;
                    break;
                end
            end
        end
        moved = recency[pos];
        res.coded_value = decoding ? moved : SYM_W'(pos);
        res.result_last = last;
        for (int j = pos; j > 0; j--)
            recency[j] = recency[j-1];
        recency[0] = moved;
        if (last)
            restore_identity();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mtf_result_t want;
        mtf_result_t got;
        if (!rst_n)
        begin
            restore_identity();
            decoding = 1'b0;
            expected_codes.delete();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                decoding = cfg_wr_data;
            if (din.valid && din.ready)
            begin
                code_byte(din.symbol, din.block_last, want);
                expected_codes.push_back(want);
            end
            if (dout.valid && dout.ready)
            begin
                got.coded_value = dout.coded_value;
                got.result_last = dout.result_last;
                if (expected_codes.size() == 0)
                begin
                    $error("unexpected result: coded_value %0d result_last %0b",
                           got.coded_value, got.result_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.coded_value !== want.coded_value)
                    begin
                        $error("coded_value: expected %0d, got %0d",
                               want.coded_value, got.coded_value);
                        mismatches++;
                    end
                    if (got.result_last !== want.result_last)
                    begin
                        $error("result_last: expected %0b, got %0b",
                               want.result_last, got.result_last);
                        mismatches++;
                    end
                end
            end
            pending    <= expected_codes.size();
            fail_count <= mismatches;
        end
    end

endmodule

[tb/testbench.sv]
// top of the move-to-front codec bench: clock, reset, stimulus, output back-pressure
// and verdict; depends on mtf_pkg, mtf_if, the codec and mtf_checker
`timescale 1ns / 1ps

module testbench;
    import mtf_pkg::*;

    // clock and reset, period 12 ns
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // channels, mode port and the block under test
    mtf_in_if  din_ch ();
    mtf_out_if dout_ch ();
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   pending;
    int   fail_count;

    move_to_front_codec dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din_ch),
        .dout        (dout_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    mtf_checker scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din_ch),
        .dout        (dout_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // calm turns off idling on both sides for a whole phase
    logic             calm;
    int               stall_left;
    int               block_left;
    logic [SYM_W-1:0] hot_base;

    // output back-pressure: rare stalls, mostly short, some long enough
    // to hold a finished result in the output register past the next transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_ch.ready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            dout_ch.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 31) == 0)
        begin
            dout_ch.ready <= 1'b0;
            stall_left    <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                          : $urandom_range(20, 400);
        end
        else
            dout_ch.ready <= 1'b1;
    end

    // input idle gaps: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transaction on the input channel; returns at the edge it is taken,
    // so valid can stay high into the next item without being dropped
    task automatic send_byte(input logic [SYM_W-1:0] sym, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid      <= 1'b1;
        din_ch.symbol     <= sym;
        din_ch.block_last <= last;
        do
            @(posedge clk);
        while (!din_ch.ready);
    endtask

    // drain everything in flight, then write the mode register while idle
    task automatic drain();
        din_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_mode(input logic decode);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= decode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // encode content: a small hot set gives short positions, the rest spans the list
    // decode content: positions near the head dominate, full range and the tail too
    function automatic logic [SYM_W-1:0] pick_value(input logic decode);
        int r;
        r = $urandom_range(0, 99);
        if (!decode)
        begin
            if (r < 45)
                return SYM_W'(hot_base + $urandom_range(0, 5));
            if (r < 90)
                return SYM_W'($urandom_range(0, 255));
            return (r < 95) ? SYM_W'(0) : SYM_W'(255);
        end
        if (r < 55)
            return SYM_W'($urandom_range(0, 3));
        if (r < 80)
            return SYM_W'($urandom_range(0, 31));
        if (r < 95)
            return SYM_W'($urandom_range(0, 255));
        return SYM_W'(255);
    endfunction

    function automatic int pick_block_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 1;
        if (r < 80)
            return $urandom_range(2, 32);
        return $urandom_range(33, 300);
    endfunction

    // blocks run across phase boundaries, so a mode change often lands mid-block
    task automatic run_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            if (block_left == 0)
            begin
                block_left = pick_block_len();
                hot_base   = SYM_W'($urandom);
            end
            block_left--;
            send_byte(pick_value(cfg_wr_data), block_left == 0);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        din_ch.valid      <= 1'b0;
        din_ch.symbol     <= '0;
        din_ch.block_last <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= 1'b0;
        calm              <= 1'b0;
        block_left        = 0;
        hot_base          = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode from a fresh list: both ends, a repeat at the head, block ends
        set_mode(1'b0);
        send_byte(8'd0,   1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd0,   1'b0);
        send_byte(8'd128, 1'b0);
        send_byte(8'd1,   1'b1);
        send_byte(8'd255, 1'b0);
        send_byte(8'd0,   1'b1);

        // decode: head and tail positions, then a switch back to encode mid-block and again to decode
        set_mode(1'b1);
        send_byte(8'd0,   1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'd0,   1'b0);
        send_byte(8'd1,   1'b0);
        send_byte(8'd200, 1'b0);
        set_mode(1'b0);
        send_byte(8'd7,   1'b0);
        send_byte(8'd255, 1'b1);
        set_mode(1'b1);
        send_byte(8'd255, 1'b1);
        send_byte(8'd170, 1'b0);
        send_byte(8'd85,  1'b1);

        // random phases, modes forced both ways first, one phase without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            set_mode((ph < 2) ? ph[0] : logic'($urandom_range(0, 1)));
            calm <= (ph == 3);
            run_random(125);
        end

        // wait out the last results, then idle on to catch any stray output
        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("move_to_front_codec verification clean");
        else
            $display("move_to_front_codec verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #50_000_000;
        $display("move_to_front_codec verification failed");
        $finish;
    end

endmodule
